// File: rtl/oaht_pkg.sv
// Shared types, codes and defaults for the open-addressing hash table core.
package oaht_pkg;

	localparam int DEF_TABLE_DEPTH  = 1024;
	localparam int DEF_PAYLOAD_BITS = 64;

	// golden fraction 0.6180339887 as an unsigned 0.32 value, truncated
	localparam logic [31:0] GOLDEN_Q32 = 32'd2654435769;

	typedef logic [1:0] cmd_t;
	typedef logic [2:0] mode_t;
	typedef logic [2:0] status_t;
	typedef logic [1:0] mark_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_DELETE = 2'd1;
	localparam cmd_t CMD_SEARCH = 2'd2;
	localparam cmd_t CMD_UNUSED = 2'd3;

	localparam mode_t MODE_LINEAR    = 3'd1;
	localparam mode_t MODE_QUADRATIC = 3'd2;
	localparam mode_t MODE_DBL_MUL   = 3'd3;
	localparam mode_t MODE_DBL_MOD   = 3'd4;

	localparam status_t STS_INSERTED  = 3'd0;
	localparam status_t STS_FOUND     = 3'd1;
	localparam status_t STS_DELETED   = 3'd2;
	localparam status_t STS_NOT_FOUND = 3'd3;
	localparam status_t STS_FULL      = 3'd4;

	localparam mark_t MARK_EMPTY   = 2'd0;
	localparam mark_t MARK_FILLED  = 2'd1;
	localparam mark_t MARK_DELETED = 2'd2;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_HASH1 = 5'b00100,
		ST_HASH2 = 5'b01000,
		ST_PROBE = 5'b10000
	} state_t;

endpackage

// File: rtl/open_addressing_hash_table_core.sv
// Top level of the open-addressing hash table core: control, hashing and probe loop.
//
// Command-driven hash table of TABLE_DEPTH slots held in two RAMs: a 2-bit mark
// (empty / filled / deleted) and a key+payload record. A word is accepted on a
// clock edge with start high and busy low; its result is shown for exactly one
// cycle with done high, and the receiver cannot hold it off. After reset the core
// sweeps the mark RAM to empty, one slot a cycle, and busy stays high until the
// sweep ends; probe mode writes are taken at any time. An insert, delete or search
// that probes k slots (1 <= k <= TABLE_DEPTH) runs from acceptance through two
// hashing states (golden-ratio multiply, then scale to the depth; low key bits
// mod the depth in MODE_DBL_MOD), a state that issues the first mark/record read,
// the probe states, which stream the probe sequence one slot per cycle through
// the single read port of each RAM, and the result cycle, in which the next word
// may already be taken. An unused command code answers "not found" in the cycle
// after acceptance without probing.
// collision_total is a saturating count of failed probes since reset.
module open_addressing_hash_table_core
	import oaht_pkg::*;
#(
	parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
	parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              cmd,
	input  logic [31:0]             key,
	input  logic [PAYLOAD_BITS-1:0] payload,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_wdata,
	output logic                    done,
	output logic [2:0]              status,
	output logic [9:0]              slot,
	output logic [PAYLOAD_BITS-1:0] found_payload,
	output logic [10:0]             probe_misses,
	output logic [31:0]             collision_total
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int MW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = 32 + PAYLOAD_BITS;

	// remainder of a narrow value by the table depth: seven compare-subtract steps
	// cover any value below 2048 for depths of 16 and up
	function automatic logic [10:0] mod_depth(input logic [10:0] x);
		logic [10:0] r;
		r = x;
		for (int k = 6; k >= 0; k--) begin
			if (32'(r) >= (TABLE_DEPTH << k)) begin
				r = r - 11'(TABLE_DEPTH << k);
			end
		end
		return r;
	endfunction

	state_t state_q;

	mode_t                   mode_q;
	cmd_t                    cmd_q;
	logic [31:0]             key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	// hashing stage
	logic [31:0] frac_s1;
	logic [10:0] h2_s1;
	logic [AW-1:0] base4_s1;

	// probe walk
	logic [AW-1:0] idx_q;
	logic [AW-1:0] inc_q;
	logic [AW-1:0] chk_idx_s1;
	logic          chk_vld_s1;
	logic [MW-1:0] miss_cnt_q;
	logic [AW-1:0] clr_cnt_q;
	logic [31:0]   coll_q;

	// result word
	logic                    done_q;
	status_t                 status_q;
	logic [9:0]              slot_q;
	logic [PAYLOAD_BITS-1:0] fpay_q;
	logic [10:0]             misses_q;

	// RAM ports
	logic          mark_we;
	logic [AW-1:0] mark_waddr;
	mark_t         mark_wdata;
	mark_t         mark_rdata;
	logic          rec_we;
	logic [RW-1:0] rec_rdata;

	// hash helpers
	logic [12:0] dsum;
	logic [10:0] dfold;
	logic [10:0] h2_c;
	logic [32+MW-1:0] prod;
	logic [AW-1:0] hm;
	logic [AW-1:0] step_c;

	// next probe index and next quadratic step
	logic [AW:0] idx_sum;
	logic [AW-1:0] idx_nxt;
	logic [AW:0] inc_sum;
	logic [AW-1:0] inc_nxt;

	// probe evaluation
	logic key_hit;
	logic term_free;
	logic term_empty;
	logic term_hit;
	logic is_miss;
	logic exhausted;
	logic [MW-1:0] miss_inc;
	logic [10:0] miss_sat;

	assign busy = (state_q != ST_IDLE);

	// key mod 1023 by summing its digits at bits 31:20, 19:10 and 9:0, then h2 = 1 + that
	assign dsum  = 13'(key_q[31:20]) + 13'(key_q[19:10]) + 13'(key_q[9:0]);
	assign dfold = 11'(dsum[9:0]) + 11'(dsum[12:10]);
	assign h2_c  = ((dfold >= 11'd1023) ? (dfold - 11'd1023) : dfold) + 11'd1;

	// multiplicative index: top bits of frac * depth
	assign prod   = {{MW{1'b0}}, frac_s1} * (32 + MW)'(TABLE_DEPTH);
	assign hm     = prod[32 +: AW];
	assign step_c = AW'(mod_depth(h2_s1));

	assign idx_sum = {1'b0, idx_q} + {1'b0, inc_q};
	assign idx_nxt = (idx_sum >= (AW + 1)'(TABLE_DEPTH)) ?
		AW'(idx_sum - (AW + 1)'(TABLE_DEPTH)) : AW'(idx_sum);
	assign inc_sum = {1'b0, inc_q} + (AW + 1)'(2);
	assign inc_nxt = (inc_sum >= (AW + 1)'(TABLE_DEPTH)) ?
		AW'(inc_sum - (AW + 1)'(TABLE_DEPTH)) : AW'(inc_sum);

	assign key_hit    = (rec_rdata[RW-1 -: 32] == key_q);
	assign term_free  = (cmd_q == CMD_INSERT) && (mark_rdata != MARK_FILLED);
	assign term_empty = (cmd_q != CMD_INSERT) && (mark_rdata == MARK_EMPTY);
	assign term_hit   = (cmd_q != CMD_INSERT) && (mark_rdata == MARK_FILLED) && key_hit;
	assign is_miss    = chk_vld_s1 && !(term_free || term_empty || term_hit);
	assign exhausted  = is_miss && (miss_cnt_q == MW'(TABLE_DEPTH - 1));
	assign miss_inc   = miss_cnt_q + MW'(1);
	assign miss_sat   = (32'(miss_cnt_q) > 32'd2047) ? 11'd2047 : 11'(miss_cnt_q);

	// writes: clearing sweep, or the terminating probe of an insert / delete
	always_comb begin
		mark_we    = 1'b0;
		mark_waddr = chk_idx_s1;
		mark_wdata = MARK_FILLED;
		rec_we     = 1'b0;
		if (state_q == ST_CLEAR) begin
			mark_we    = 1'b1;
			mark_waddr = clr_cnt_q;
			mark_wdata = MARK_EMPTY;
		end else if (state_q == ST_PROBE && chk_vld_s1) begin
			if (term_free) begin
				mark_we = 1'b1;
				rec_we  = 1'b1;
			end else if (term_hit && cmd_q == CMD_DELETE) begin
				mark_we    = 1'b1;
				mark_wdata = MARK_DELETED;
			end
		end
	end

	oaht_ram #(
		.WIDTH(2),
		.DEPTH(TABLE_DEPTH)
	) u_mark_ram (
		.clk  (clk),
		.we   (mark_we),
		.waddr(mark_waddr),
		.wdata(mark_wdata),
		.raddr(idx_q),
		.rdata(mark_rdata)
	);

	oaht_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_DEPTH)
	) u_rec_ram (
		.clk  (clk),
		.we   (rec_we),
		.waddr(chk_idx_s1),
		.wdata({key_q, pay_q}),
		.raddr(idx_q),
		.rdata(rec_rdata)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			mode_q     <= MODE_LINEAR;
			clr_cnt_q  <= '0;
			chk_vld_s1 <= 1'b0;
			miss_cnt_q <= '0;
			coll_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						miss_cnt_q <= '0;
						if (cmd == CMD_UNUSED) begin
							// unused command: no probing, immediate not found
							done_q <= 1'b1;
						end else begin
							state_q <= ST_HASH1;
						end
					end
				end
				ST_HASH1: begin
					state_q <= ST_HASH2;
				end
				ST_HASH2: begin
					chk_vld_s1 <= 1'b0;
					state_q    <= ST_PROBE;
				end
				ST_PROBE: begin
					chk_vld_s1 <= 1'b1;
					if (is_miss) begin
						miss_cnt_q <= miss_inc;
						if (coll_q != 32'hFFFF_FFFF) begin
							coll_q <= coll_q + 32'd1;
						end
					end
					if (chk_vld_s1 && (!is_miss || exhausted)) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q <= cmd;
					key_q <= key;
					pay_q <= payload;
					if (cmd == CMD_UNUSED) begin
						status_q <= STS_NOT_FOUND;
						slot_q   <= '0;
						fpay_q   <= '0;
						misses_q <= '0;
					end
				end
			end
			ST_HASH1: begin
				frac_s1  <= key_q * GOLDEN_Q32;
				h2_s1    <= h2_c;
				base4_s1 <= AW'(mod_depth(11'(key_q[9:0])));
			end
			ST_HASH2: begin
				case (mode_q)
					MODE_LINEAR, MODE_QUADRATIC: begin
						idx_q <= hm;
						inc_q <= AW'(1);
					end
					MODE_DBL_MUL: begin
						idx_q <= hm;
						inc_q <= step_c;
					end
					MODE_DBL_MOD: begin
						idx_q <= base4_s1;
						inc_q <= step_c;
					end
					default: begin
						// unused mode: every probe lands on slot zero
						idx_q <= '0;
						inc_q <= '0;
					end
				endcase
			end
			ST_PROBE: begin
				chk_idx_s1 <= idx_q;
				idx_q      <= idx_nxt;
				if (mode_q == MODE_QUADRATIC) begin
					inc_q <= inc_nxt;
				end
				if (chk_vld_s1) begin
					fpay_q   <= '0;
					slot_q   <= '0;
					misses_q <= miss_sat;
					if (term_free) begin
						status_q <= STS_INSERTED;
						slot_q   <= 10'(chk_idx_s1);
					end else if (term_hit) begin
						slot_q <= 10'(chk_idx_s1);
						if (cmd_q == CMD_DELETE) begin
							status_q <= STS_DELETED;
						end else begin
							status_q <= STS_FOUND;
							fpay_q   <= rec_rdata[PAYLOAD_BITS-1:0];
						end
					end else if (term_empty) begin
						status_q <= STS_NOT_FOUND;
					end else begin
						status_q <= (cmd_q == CMD_INSERT) ? STS_FULL : STS_NOT_FOUND;
						misses_q <= (32'(miss_inc) > 32'd2047) ? 11'd2047 : 11'(miss_inc);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign done            = done_q;
	assign status          = status_q;
	assign slot            = slot_q;
	assign found_payload   = fpay_q;
	assign probe_misses    = misses_q;
	assign collision_total = coll_q;

`ifndef SYNTHESIS
	// mark RAM is only written by the clearing sweep or a terminating probe
	a_mark_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mark_we |-> (state_q == ST_CLEAR || state_q == ST_PROBE))
		else $error("mark write outside clear or probe");

	// probe walk stays inside the table
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (32'(idx_q) < TABLE_DEPTH && 32'(inc_q) < TABLE_DEPTH))
		else $error("probe index or step out of range");

	// never more misses than slots
	a_miss_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(miss_cnt_q) <= TABLE_DEPTH)
		else $error("miss count beyond table depth");

	// an inserted result follows a filled-mark write in the previous cycle
	a_insert_wrote: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == STS_INSERTED) |->
			$past(mark_we && rec_we && mark_wdata == MARK_FILLED))
		else $error("insert reported without a slot write");
`endif

endmodule

// File: rtl/oaht_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the open-addressing hash table core: predictor, driver, monitor.
module tb;
	import oaht_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH    = DEF_TABLE_DEPTH;
	localparam int PAY_W    = DEF_PAYLOAD_BITS;
	// no accepted word and no answer for this many cycles means the core has hung;
	// covers the clearing sweep plus a full-depth probe, several times over
	localparam int HANG_LIMIT = 12000;

	// codes the package leaves unnamed
	localparam mode_t MODE_UNUSED_LO = 3'd0;
	localparam mode_t MODE_UNUSED_HI = 3'd7;

	localparam int NUM_PHASES      = 6;
	localparam int WORDS_PER_PHASE = 290;

	typedef struct {
		status_t        status;
		logic [9:0]     slot_idx;
		logic [63:0]    data;
		logic [10:0]    misses;
		logic [31:0]    total;
	} answer_t;

	// Shadow of the table: works out each answer as a word is accepted and
	// checks the answers in order as they appear.
	class table_checker;
		mode_t       probe_mode;
		mark_t       slot_state[DEPTH];
		logic [31:0] slot_tag[DEPTH];
		logic [63:0] slot_data[DEPTH];
		logic [31:0] miss_total;
		answer_t     pending_answers[$];
		int          mismatches;

		function new();
			probe_mode = MODE_LINEAR;
			miss_total = '0;
			mismatches = 0;
			foreach (slot_state[i])
				slot_state[i] = MARK_EMPTY;
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction

		task report(string what);
			$display("[%0t] MISMATCH: %s", $realtime, what);
			mismatches++;
		endtask

		// slot visited on probe number i
		function int unsigned probe_index(int unsigned home, int unsigned stride,
				logic [31:0] k, int unsigned i);
			case (probe_mode)
				MODE_LINEAR:    return (home + i) % DEPTH;
				MODE_QUADRATIC: return (home + i * i) % DEPTH;
				MODE_DBL_MUL:   return (home + i * stride) % DEPTH;
				MODE_DBL_MOD:   return (k % 1024 + i * stride) % DEPTH;
				default:        return 0;
			endcase
		endfunction

		function void note_command(cmd_t c, logic [31:0] k, logic [63:0] p);
			answer_t     a;
			logic [31:0] frac;
			int unsigned home, stride, s, i;
			bit          stop;
			a.status   = STS_NOT_FOUND;
			a.slot_idx = '0;
			a.data     = '0;
			a.misses   = '0;
			if (c != CMD_UNUSED) begin
				a.status = (c == CMD_INSERT) ? STS_FULL : STS_NOT_FOUND;
				// golden-ratio hash in 0.32 fixed point, top bits scaled to the depth
				frac   = k * GOLDEN_Q32;
				home   = int'((64'(frac) * DEPTH) >> 32);
				stride = 1 + k % 1023;
				stop   = 1'b0;
				for (i = 0; i < DEPTH && !stop; i++) begin
					s = probe_index(home, stride, k, i);
					if (c == CMD_INSERT) begin
						if (slot_state[s] != MARK_FILLED) begin
							slot_state[s] = MARK_FILLED;
							slot_tag[s]   = k;
							slot_data[s]  = p;
							a.status      = STS_INSERTED;
							a.slot_idx    = s[9:0];
							stop          = 1'b1;
						end
					end else if (slot_state[s] == MARK_EMPTY) begin
						stop = 1'b1;
					end else if (slot_state[s] == MARK_FILLED && slot_tag[s] == k) begin
						a.slot_idx = s[9:0];
						if (c == CMD_DELETE) begin
							slot_state[s] = MARK_DELETED;
							a.status      = STS_DELETED;
						end else begin
							a.status = STS_FOUND;
							a.data   = slot_data[s];
						end
						stop = 1'b1;
					end
					if (!stop) begin
						if (a.misses != 11'h7FF)
							a.misses++;
						if (miss_total != 32'hFFFF_FFFF)
							miss_total++;
					end
				end
			end
			a.total = miss_total;
			pending_answers.push_back(a);
		endfunction

		task check_answer(status_t st, logic [9:0] sl, logic [63:0] fp,
				logic [10:0] pm, logic [31:0] ct);
			answer_t a;
			if (pending_answers.size() == 0) begin
				report($sformatf("answer with nothing outstanding, status %0d", st));
				return;
			end
			a = pending_answers.pop_front();
			if (st !== a.status)
				report($sformatf("status %0d, want %0d", st, a.status));
			if (sl !== a.slot_idx)
				report($sformatf("slot %0d, want %0d", sl, a.slot_idx));
			if (fp !== a.data)
				report($sformatf("found_payload %h, want %h", fp, a.data));
			if (pm !== a.misses)
				report($sformatf("probe_misses %0d, want %0d", pm, a.misses));
			if (ct !== a.total)
				report($sformatf("collision_total %0d, want %0d", ct, a.total));
		endtask
	endclass

	// ---------------------------------------------------------------------
	// DUT hookup; every input known from time zero
	// ---------------------------------------------------------------------
	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	cmd_t             cmd       = CMD_INSERT;
	logic [31:0]      key       = '0;
	logic [PAY_W-1:0] payload   = '0;
	logic             cfg_we    = 1'b0;
	mode_t            cfg_wdata = MODE_LINEAR;
	logic             busy;
	logic             done;
	status_t          status;
	logic [9:0]       slot;
	logic [PAY_W-1:0] found_payload;
	logic [10:0]      probe_misses;
	logic [31:0]      collision_total;

	open_addressing_hash_table_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.key            (key),
		.payload        (payload),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.done           (done),
		.status         (status),
		.slot           (slot),
		.found_payload  (found_payload),
		.probe_misses   (probe_misses),
		.collision_total(collision_total)
	);

	always #2 clk = ~clk;

	table_checker sb = new();

	// keys reused across the run so that searches and deletes mostly hit
	logic [31:0] key_pool[64];

	// ---------------------------------------------------------------------
	// Answer monitor: done marks one cycle, taken at the edge that ends it
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_answer(status, slot, found_payload, probe_misses, collision_total);
	end

	// ---------------------------------------------------------------------
	// Hang watchdog: restarts on any accepted word or any answer
	// ---------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Driver tasks; all called at a rising edge, inputs changed by NBA
	// ---------------------------------------------------------------------

	// present one word and hold it until an edge sees start high with busy low
	task send_word(cmd_t c, logic [31:0] k, logic [63:0] p);
		cmd     <= c;
		key     <= k;
		payload <= p;
		start   <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(c, k, p);
	endtask

	// drop start and let every outstanding answer come back
	task drain();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// mode changes only with the core quiet and nothing outstanding
	task set_mode(mode_t m);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		sb.probe_mode = m;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function logic [31:0] pick_key();
		if ($urandom_range(0, 99) < 88)
			return key_pool[$urandom_range(0, 63)];
		return $urandom;
	endfunction

	// one random word: mostly pool keys, a few unused command codes
	task send_random();
		int          r;
		logic [63:0] p;
		r = $urandom_range(0, 99);
		p = {$urandom, $urandom};
		if (r < 35)
			send_word(CMD_INSERT, pick_key(), p);
		else if (r < 67)
			send_word(CMD_DELETE, pick_key(), p);
		else if (r < 96)
			send_word(CMD_SEARCH, pick_key(), p);
		else
			send_word(CMD_UNUSED, $urandom, p);
	endtask

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	mode_t phase_mode[NUM_PHASES] = '{MODE_LINEAR, MODE_QUADRATIC, MODE_DBL_MUL,
		MODE_DBL_MOD, MODE_QUADRATIC, MODE_DBL_MOD};
	// sender idle chance per word; zero phases give back-to-back traffic
	int    phase_idle[NUM_PHASES] = '{0, 54, 0, 35, 54, 35};

	initial begin
		int ph, n;
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (n = 2; n < 64; n++)
			key_pool[n] = $urandom;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// core sweeps the marks after reset; the first word just waits on busy
		set_mode(MODE_LINEAR);

		// -- directed: field extremes, every command, duplicates, tombstones
		send_word(CMD_INSERT, 32'h0000_0000, 64'h0);
		send_word(CMD_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(CMD_SEARCH, 32'h0000_0000, 64'h0);
		send_word(CMD_SEARCH, 32'hFFFF_FFFF, 64'h0);
		// same key again takes a second slot
		send_word(CMD_INSERT, 32'h0000_0000, 64'hA5A5_5A5A_0F0F_F0F0);
		send_word(CMD_DELETE, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
		// second copy found past the deleted slot
		send_word(CMD_SEARCH, 32'h0000_0000, 64'h0);
		send_word(CMD_SEARCH, 32'h1234_5678, 64'h0);
		send_word(CMD_DELETE, 32'h8765_4321, 64'h0);
		send_word(CMD_UNUSED, 32'hDEAD_BEEF, 64'h5555_AAAA_5555_AAAA);
		send_word(CMD_INSERT, 32'h8000_0001, 64'h8000_0000_0000_0001);

		// unused mode: every probe lands on slot 0, so full table and
		// exhausted search are cheap to reach
		set_mode(MODE_UNUSED_LO);
		send_word(CMD_INSERT, 32'd7, 64'h0123_4567_89AB_CDEF);
		send_word(CMD_INSERT, 32'd8, 64'h1);
		send_word(CMD_SEARCH, 32'd9, 64'h0);
		send_word(CMD_DELETE, 32'd9, 64'h0);
		send_word(CMD_SEARCH, 32'd7, 64'h0);

		set_mode(MODE_UNUSED_HI);
		send_word(CMD_DELETE, 32'd7, 64'h0);
		send_word(CMD_INSERT, 32'd9, 64'hFEDC_BA98_7654_3210);
		send_word(CMD_SEARCH, 32'd9, 64'h0);
		send_word(CMD_DELETE, 32'd9, 64'h0);

		// -- random phases, one probe mode and idle pattern each
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			set_mode(phase_mode[ph]);
			for (n = 0; n < WORDS_PER_PHASE; n++) begin
				send_random();
				if (phase_idle[ph] == 0 && n % 64 == 63) begin
					// hold off until the core has answered everything
					drain();
				end else if ($urandom_range(0, 99) < phase_idle[ph]) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
